// ----- design/lzti_pkg.sv -----
// Shared constants for the LZSS tree insert and match unit.
`timescale 1ns / 1ps
`default_nettype none

package lzti_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int MAX_MATCH_DEF   = 18;

    // Number of tree roots, one per leading byte value
    localparam int ROOT_COUNT = 256;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

endpackage

`default_nettype wire

// ----- design/lzss_tree_insert_match_unit.sv -----
// Top level of the LZSS binary-tree insert and longest-match unit.
//
// Usage: present operation, position and byte_value with start high; the request
// is taken at a clock edge where start is high and busy is low. A write request
// stores byte_value into the text store; an insert request adds the string at
// position to the tree of its leading byte and reports the longest match found.
// Every request gives exactly one result: done is high for one cycle with
// match_position and match_length valid. The receiver cannot stall.
// Writes and inserts at or beyond the window answer in the cycle after
// acceptance and leave busy low. An insert reads the root of its leading byte,
// then for each tree node visited fetches a link and compares bytes (1 to
// MAX_MATCH-1); a full-length match then replaces the old node. The walk, with its
// one-byte-per-cycle compare over the duplicated text RAM, sets the rate.
// Reset: all links are swept to nil, one entry a cycle over WINDOW_SIZE+257
// entries (4353 at the default window); busy stays high until the sweep ends.
// The text store is not cleared and must be written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module lzss_tree_insert_match_unit #(
    parameter int WINDOW_SIZE = lzti_pkg::WINDOW_SIZE_DEF,
    parameter int MAX_MATCH   = lzti_pkg::MAX_MATCH_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       start,
    output logic                                            busy,
    input  wire logic                                       operation,
    input  wire logic [$clog2(WINDOW_SIZE+MAX_MATCH-1)-1:0] position,
    input  wire logic [7:0]                                 byte_value,
    output logic                                            done,
    output logic      [$clog2(WINDOW_SIZE)-1:0]             match_position,
    output logic      [$clog2(MAX_MATCH+1)-1:0]             match_length
);

    localparam int TEXT_DEPTH   = WINDOW_SIZE + MAX_MATCH - 1;
    localparam int LEFT_DEPTH   = WINDOW_SIZE + 1;
    localparam int RIGHT_DEPTH  = WINDOW_SIZE + lzti_pkg::ROOT_COUNT + 1;
    localparam int PARENT_DEPTH = WINDOW_SIZE + 1;

    localparam int TA_W   = $clog2(TEXT_DEPTH);
    localparam int LA_W   = $clog2(LEFT_DEPTH);
    localparam int RA_W   = $clog2(RIGHT_DEPTH);
    localparam int PA_W   = $clog2(PARENT_DEPTH);
    localparam int LINK_W = RA_W;
    localparam int MPOS_W = $clog2(WINDOW_SIZE);
    localparam int LEN_W  = $clog2(MAX_MATCH + 1);
    localparam int IDX_W  = $clog2(MAX_MATCH);
    localparam int VIS_W  = $clog2(WINDOW_SIZE + 2);

    localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(WINDOW_SIZE);
    localparam logic [LINK_W-1:0] ROOT_BASE = LINK_W'(WINDOW_SIZE + 1);
    localparam logic [LINK_W:0]   LEFT_LIM  = (LINK_W + 1)'(LEFT_DEPTH);
    localparam logic [LINK_W:0]   RIGHT_LIM = (LINK_W + 1)'(RIGHT_DEPTH);
    localparam logic [LINK_W:0]   PAR_LIM   = (LINK_W + 1)'(PARENT_DEPTH);
    localparam logic [TA_W:0]     TEXT_LIM  = (TA_W + 1)'(TEXT_DEPTH);
    localparam logic [TA_W:0]     WIN_LIM   = (TA_W + 1)'(WINDOW_SIZE);
    localparam logic [RA_W-1:0]   CLR_LAST  = RA_W'(RIGHT_DEPTH - 1);
    localparam logic [VIS_W-1:0]  VIS_LIMIT = VIS_W'(WINDOW_SIZE + 1);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(MAX_MATCH - 1);
    localparam logic [LEN_W-1:0]  LEN_FULL  = LEN_W'(MAX_MATCH);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_ROOT  = 12'b000000000100,
        S_FETCH = 12'b000000001000,
        S_NEXT  = 12'b000000010000,
        S_CMP   = 12'b000000100000,
        S_REP1  = 12'b000001000000,
        S_REP2  = 12'b000010000000,
        S_REP3  = 12'b000100000000,
        S_REP4  = 12'b001000000000,
        S_REP5  = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    function automatic logic in_left(input logic [LINK_W-1:0] idx);
        in_left = {1'b0, idx} < LEFT_LIM;
    endfunction

    function automatic logic in_right(input logic [LINK_W-1:0] idx);
        in_right = {1'b0, idx} < RIGHT_LIM;
    endfunction

    function automatic logic in_parent(input logic [LINK_W-1:0] idx);
        in_parent = {1'b0, idx} < PAR_LIM;
    endfunction

    // Control registers
    state_t            state_reg, state_next;
    logic [RA_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic              done_reg, done_next;

    // Working registers
    logic [LINK_W-1:0] node_reg, node_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] up_reg, up_next;
    logic [LINK_W-1:0] lo_reg, lo_next;
    logic [LINK_W-1:0] hi_reg, hi_next;
    logic              diff_neg_reg, diff_neg_next;
    logic              oob_reg, oob_next;
    logic              up_hit_reg, up_hit_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [VIS_W-1:0]  visits_reg, visits_next;
    logic [MPOS_W-1:0] best_pos_reg, best_pos_next;
    logic [LEN_W-1:0]  best_len_reg, best_len_next;
    logic [MPOS_W-1:0] match_position_reg, match_position_next;
    logic [LEN_W-1:0]  match_length_reg, match_length_next;

    // Memory ports
    logic              text_we;
    logic [TA_W-1:0]   text_a_raddr, text_b_raddr;
    logic [7:0]        text_a_rdata, text_b_rdata;
    logic              left_we, right_we, parent_we;
    logic [LA_W-1:0]   left_waddr, left_raddr;
    logic [RA_W-1:0]   right_waddr, right_raddr;
    logic [PA_W-1:0]   parent_waddr, parent_raddr;
    logic [LINK_W-1:0] left_wdata, right_wdata, parent_wdata;
    logic [LINK_W-1:0] left_rdata, right_rdata, parent_rdata;

    logic              accept;
    logic [LINK_W-1:0] pos_link;
    logic [LINK_W-1:0] next_link;
    logic [TA_W-1:0]   node_ta;
    logic [TA_W-1:0]   cur_ta;
    logic [TA_W-1:0]   next_ta;
    logic [LEN_W-1:0]  node_len;
    logic              node_end;

    assign busy           = (state_reg != S_IDLE);
    assign accept         = start && !busy;
    assign done           = done_reg;
    assign match_position = match_position_reg;
    assign match_length   = match_length_reg;

    assign pos_link  = LINK_W'(position);
    assign next_link = oob_reg ? NIL_LINK : (diff_neg_reg ? left_rdata : right_rdata);
    assign node_ta   = node_reg[TA_W-1:0];
    assign cur_ta    = cur_reg[TA_W-1:0];
    assign next_ta   = next_link[TA_W-1:0];

    // Text store is duplicated so both strings advance one byte a cycle
    lzti_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text_a (
        .clk   (clk),
        .we    (text_we),
        .waddr (position),
        .wdata (byte_value),
        .raddr (text_a_raddr),
        .rdata (text_a_rdata)
    );

    lzti_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text_b (
        .clk   (clk),
        .we    (text_we),
        .waddr (position),
        .wdata (byte_value),
        .raddr (text_b_raddr),
        .rdata (text_b_rdata)
    );

    lzti_ram #(.WIDTH(LINK_W), .DEPTH(LEFT_DEPTH)) u_left (
        .clk   (clk),
        .we    (left_we),
        .waddr (left_waddr),
        .wdata (left_wdata),
        .raddr (left_raddr),
        .rdata (left_rdata)
    );

    lzti_ram #(.WIDTH(LINK_W), .DEPTH(RIGHT_DEPTH)) u_right (
        .clk   (clk),
        .we    (right_we),
        .waddr (right_waddr),
        .wdata (right_wdata),
        .raddr (right_raddr),
        .rdata (right_rdata)
    );

    lzti_ram #(.WIDTH(LINK_W), .DEPTH(PARENT_DEPTH)) u_parent (
        .clk   (clk),
        .we    (parent_we),
        .waddr (parent_waddr),
        .wdata (parent_wdata),
        .raddr (parent_raddr),
        .rdata (parent_rdata)
    );

    always_comb
    begin
        state_next          = state_reg;
        clr_cnt_next        = clr_cnt_reg;
        done_next           = 1'b0;
        node_next           = node_reg;
        cur_next            = cur_reg;
        up_next             = up_reg;
        lo_next             = lo_reg;
        hi_next             = hi_reg;
        diff_neg_next       = diff_neg_reg;
        oob_next            = oob_reg;
        up_hit_next         = up_hit_reg;
        idx_next            = idx_reg;
        visits_next         = visits_reg;
        best_pos_next       = best_pos_reg;
        best_len_next       = best_len_reg;
        match_position_next = match_position_reg;
        match_length_next   = match_length_reg;

        text_we      = 1'b0;
        text_a_raddr = '0;
        text_b_raddr = '0;
        left_we      = 1'b0;
        left_waddr   = '0;
        left_wdata   = NIL_LINK;
        left_raddr   = '0;
        right_we     = 1'b0;
        right_waddr  = '0;
        right_wdata  = NIL_LINK;
        right_raddr  = '0;
        parent_we    = 1'b0;
        parent_waddr = '0;
        parent_wdata = NIL_LINK;
        parent_raddr = '0;

        node_len = LEN_FULL;
        node_end = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep every link entry to nil
                left_we      = in_left(clr_cnt_reg);
                left_waddr   = clr_cnt_reg[LA_W-1:0];
                right_we     = 1'b1;
                right_waddr  = clr_cnt_reg;
                parent_we    = in_parent(clr_cnt_reg);
                parent_waddr = clr_cnt_reg[PA_W-1:0];
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == lzti_pkg::OP_WRITE)
                    begin
                        text_we             = {1'b0, position} < TEXT_LIM;
                        done_next           = 1'b1;
                        match_position_next = '0;
                        match_length_next   = '0;
                    end
                    else if ({1'b0, position} >= WIN_LIM)
                    begin
                        done_next           = 1'b1;
                        match_position_next = '0;
                        match_length_next   = '0;
                    end
                    else
                    begin
                        node_next     = pos_link;
                        text_a_raddr  = position;
                        left_we       = 1'b1;
                        left_waddr    = pos_link[LA_W-1:0];
                        right_we      = 1'b1;
                        right_waddr   = pos_link;
                        best_pos_next = '0;
                        best_len_next = '0;
                        state_next    = S_ROOT;
                    end
                end
            end

            S_ROOT:
            begin
                cur_next      = ROOT_BASE + LINK_W'(text_a_rdata);
                diff_neg_next = 1'b0;
                visits_next   = '0;
                state_next    = S_FETCH;
            end

            S_FETCH:
            begin
                if (visits_reg == VIS_LIMIT)
                begin
                    // Runaway walk: leave the new node unattached
                    state_next = S_DONE;
                end
                else
                begin
                    if (diff_neg_reg)
                    begin
                        left_raddr = cur_reg[LA_W-1:0];
                        oob_next   = !in_left(cur_reg);
                    end
                    else
                    begin
                        right_raddr = cur_reg;
                        oob_next    = !in_right(cur_reg);
                    end
                    state_next = S_NEXT;
                end
            end

            S_NEXT:
            begin
                if (next_link == NIL_LINK)
                begin
                    // Attach the new node as a leaf
                    if (diff_neg_reg)
                    begin
                        left_we    = in_left(cur_reg);
                        left_waddr = cur_reg[LA_W-1:0];
                        left_wdata = node_reg;
                    end
                    else
                    begin
                        right_we    = in_right(cur_reg);
                        right_waddr = cur_reg;
                        right_wdata = node_reg;
                    end
                    parent_we    = 1'b1;
                    parent_waddr = node_reg[PA_W-1:0];
                    parent_wdata = cur_reg;
                    state_next   = S_DONE;
                end
                else
                begin
                    cur_next     = next_link;
                    idx_next     = IDX_W'(1);
                    text_a_raddr = node_ta + TA_W'(1);
                    text_b_raddr = next_ta + TA_W'(1);
                    state_next   = S_CMP;
                end
            end

            S_CMP:
            begin
                // Bytes at idx_reg arrive now; the next pair is fetched alongside
                if (text_a_rdata != text_b_rdata)
                begin
                    node_len = LEN_W'(idx_reg);
                    node_end = 1'b1;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    node_len = LEN_FULL;
                    node_end = 1'b1;
                end
                else
                begin
                    idx_next     = idx_reg + 1'b1;
                    text_a_raddr = node_ta + TA_W'(idx_reg) + TA_W'(1);
                    text_b_raddr = cur_ta + TA_W'(idx_reg) + TA_W'(1);
                end

                if (node_end)
                begin
                    if (node_len > best_len_reg)
                    begin
                        best_pos_next = cur_reg[MPOS_W-1:0];
                        best_len_next = node_len;
                    end
                    if (node_len == LEN_FULL)
                    begin
                        state_next = S_REP1;
                    end
                    else
                    begin
                        visits_next   = visits_reg + 1'b1;
                        diff_neg_next = text_a_rdata < text_b_rdata;
                        state_next    = S_FETCH;
                    end
                end
            end

            S_REP1:
            begin
                parent_raddr = cur_reg[PA_W-1:0];
                left_raddr   = cur_reg[LA_W-1:0];
                right_raddr  = cur_reg;
                state_next   = S_REP2;
            end

            S_REP2:
            begin
                // New node takes over the old node's links
                up_next      = parent_rdata;
                lo_next      = left_rdata;
                hi_next      = right_rdata;
                parent_we    = 1'b1;
                parent_waddr = node_reg[PA_W-1:0];
                parent_wdata = parent_rdata;
                left_we      = 1'b1;
                left_waddr   = node_reg[LA_W-1:0];
                left_wdata   = left_rdata;
                right_we     = 1'b1;
                right_waddr  = node_reg;
                right_wdata  = right_rdata;
                state_next   = S_REP3;
            end

            S_REP3:
            begin
                parent_we    = in_parent(lo_reg);
                parent_waddr = lo_reg[PA_W-1:0];
                parent_wdata = node_reg;
                // Read after the right-link write of the previous cycle has landed
                right_raddr  = up_reg;
                oob_next     = !in_right(up_reg);
                state_next   = S_REP4;
            end

            S_REP4:
            begin
                parent_we    = in_parent(hi_reg);
                parent_waddr = hi_reg[PA_W-1:0];
                parent_wdata = node_reg;
                up_hit_next  = !oob_reg && (right_rdata == cur_reg);
                state_next   = S_REP5;
            end

            S_REP5:
            begin
                if (up_hit_reg)
                begin
                    right_we    = 1'b1;
                    right_waddr = up_reg;
                    right_wdata = node_reg;
                end
                else
                begin
                    left_we    = in_left(up_reg);
                    left_waddr = up_reg[LA_W-1:0];
                    left_wdata = node_reg;
                end
                // Detach the old node
                parent_we    = 1'b1;
                parent_waddr = cur_reg[PA_W-1:0];
                parent_wdata = NIL_LINK;
                state_next   = S_DONE;
            end

            S_DONE:
            begin
                done_next           = 1'b1;
                match_position_next = best_pos_reg;
                match_length_next   = best_len_reg;
                state_next          = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg           <= node_next;
        cur_reg            <= cur_next;
        up_reg             <= up_next;
        lo_reg             <= lo_next;
        hi_reg             <= hi_next;
        diff_neg_reg       <= diff_neg_next;
        oob_reg            <= oob_next;
        up_hit_reg         <= up_hit_next;
        idx_reg            <= idx_next;
        visits_reg         <= visits_next;
        best_pos_reg       <= best_pos_next;
        best_len_reg       <= best_len_next;
        match_position_reg <= match_position_next;
        match_length_reg   <= match_length_next;
    end

    // A write request answers in the next cycle with zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == lzti_pkg::OP_WRITE) |=> (done && match_length == '0))
        else $error("write request did not answer with zero length");

    // The end of a walk always yields exactly one result and frees the unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> (done && !busy))
        else $error("walk finished without a result");

    // Reported length never exceeds the longest possible match
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (match_length <= LEN_FULL))
        else $error("match length out of range");

    // Compare index stays inside the string while comparing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (idx_reg != '0 && idx_reg <= IDX_LAST))
        else $error("compare index out of range");

endmodule

`default_nettype wire

// ----- design/lzti_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lzti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the LZSS binary-tree insert and longest-match unit.
`timescale 1ns / 1ps

module tb_top;

    import lzti_pkg::*;

    localparam int WINDOW       = WINDOW_SIZE_DEF;
    localparam int MATCH_MAX    = MAX_MATCH_DEF;
    localparam int TEXT_DEPTH   = WINDOW + MATCH_MAX - 1;
    localparam int LEFT_DEPTH   = WINDOW + 1;
    localparam int RIGHT_DEPTH  = WINDOW + ROOT_COUNT + 1;
    localparam int PARENT_DEPTH = WINDOW + 1;
    localparam int POS_W        = $clog2(TEXT_DEPTH);
    localparam int POS_MAX      = (1 << POS_W) - 1;

    localparam int STALL_LIMIT     = 500000;
    localparam int TAIL_CYCLES     = 64;
    localparam int RANDOM_REQUESTS = 620;
    localparam int CALM_REQUESTS   = 80;
    localparam int TEXT_BYTE_MAX   = 253;

    // The directed strings sit at the top of the window under a leading byte
    // that random text never uses, since they leave a looping tree behind
    localparam int         PROBE_BASE = WINDOW - 3;
    localparam logic [7:0] PROBE_LEAD = 8'hFF;

    typedef logic [12:0] link_t;
    localparam link_t NIL = link_t'(WINDOW);

    typedef struct packed {
        logic [11:0] pos;
        logic [4:0]  len;
    } match_t;

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] pos;
        logic [7:0]       val;
        logic [7:0]       reps;
        logic             typed;
        match_t           want;
    } stim_row_t;

    typedef enum int {TEXT_NOISY, TEXT_SPARSE, TEXT_PERIODIC} text_kind_t;
    typedef enum int {NOISE_FAR_WRITE, NOISE_FAR_INSERT, NOISE_REWRITE} noise_kind_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             operation;
    logic [POS_W-1:0] position;
    logic [7:0]       byte_value;
    logic             done;
    logic [11:0]      match_position;
    logic [4:0]       match_length;

    // Shadow of the block's text store and tree links
    logic [7:0] text_mem    [TEXT_DEPTH];
    link_t      left_link   [LEFT_DEPTH];
    link_t      right_link  [RIGHT_DEPTH];
    link_t      parent_link [PARENT_DEPTH];

    match_t pending_matches[$];

    int unsigned mismatch_count;
    int unsigned requests_sent;
    int unsigned results_seen;
    int unsigned inserts_walked;
    int unsigned full_replacements;
    int unsigned runaway_walks;
    int unsigned far_requests;
    int unsigned stall_cycles = 0;

    stim_row_t directed_rows [11] = '{
        '{OP_WRITE,  POS_W'(POS_MAX),        8'hA5,      8'd1,  1'b1, '{12'd0, 5'd0}},
        '{OP_WRITE,  POS_W'(TEXT_DEPTH),     8'h5A,      8'd1,  1'b1, '{12'd0, 5'd0}},
        '{OP_INSERT, POS_W'(WINDOW),         8'hFF,      8'd1,  1'b1, '{12'd0, 5'd0}},
        '{OP_INSERT, POS_W'(POS_MAX),        8'h00,      8'd1,  1'b1, '{12'd0, 5'd0}},
        // A run of the probe byte, then two zero bytes ending at the last address
        '{OP_WRITE,  POS_W'(PROBE_BASE),     PROBE_LEAD, 8'd18, 1'b1, '{12'd0, 5'd0}},
        '{OP_WRITE,  POS_W'(TEXT_DEPTH - 2), 8'h00,      8'd2,  1'b1, '{12'd0, 5'd0}},
        // First string into an empty tree
        '{OP_INSERT, POS_W'(PROBE_BASE),     8'h3C,      8'd1,  1'b1, '{12'd0, 5'd0}},
        // Second string differs in its last byte and hangs below the first
        '{OP_INSERT, POS_W'(PROBE_BASE + 1), 8'hC3,      8'd1,  1'b0, '{12'd0, 5'd0}},
        '{OP_WRITE,  POS_W'(TEXT_DEPTH - 2), PROBE_LEAD, 8'd1,  1'b1, '{12'd0, 5'd0}},
        // Re-insert it as a full-length match: it replaces its parent and links to itself
        '{OP_INSERT, POS_W'(PROBE_BASE + 1), 8'h81,      8'd1,  1'b0, '{12'd0, 5'd0}},
        // The next string walks into that loop until the visit limit stops it
        '{OP_INSERT, POS_W'(PROBE_BASE + 2), 8'h7E,      8'd1,  1'b0, '{12'd0, 5'd0}}
    };

    lzss_tree_insert_match_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .position       (position),
        .byte_value     (byte_value),
        .done           (done),
        .match_position (match_position),
        .match_length   (match_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] text_at(input int unsigned idx);
        return (idx < TEXT_DEPTH) ? text_mem[idx] : 8'h00;
    endfunction

    function automatic link_t left_of(input int unsigned idx);
        return (idx < LEFT_DEPTH) ? left_link[idx] : NIL;
    endfunction

    function automatic link_t right_of(input int unsigned idx);
        return (idx < RIGHT_DEPTH) ? right_link[idx] : NIL;
    endfunction

    function automatic link_t parent_of(input int unsigned idx);
        return (idx < PARENT_DEPTH) ? parent_link[idx] : NIL;
    endfunction

    // Link writes outside an array are dropped
    function automatic void set_left(input int unsigned idx, input link_t val);
        if (idx < LEFT_DEPTH)
            left_link[idx] = val;
    endfunction

    function automatic void set_right(input int unsigned idx, input link_t val);
        if (idx < RIGHT_DEPTH)
            right_link[idx] = val;
    endfunction

    function automatic void set_parent(input int unsigned idx, input link_t val);
        if (idx < PARENT_DEPTH)
            parent_link[idx] = val;
    endfunction

    // Apply one request to the shadow state and return the match it should report
    function automatic match_t predict_match(input logic op, input logic [POS_W-1:0] pos,
                                             input logic [7:0] val);
        match_t      res;
        link_t       node;
        link_t       cur;
        link_t       next;
        link_t       up;
        link_t       lo;
        link_t       hi;
        int          diff;
        int unsigned best_len;
        int unsigned n_cmp;
        int unsigned visits;
        bit          full;

        res = '0;
        diff = 1;
        best_len = 0;
        full = 1'b0;
        if (op == OP_WRITE)
        begin
            if (pos < TEXT_DEPTH)
                text_mem[pos] = val;
            return res;
        end
        if (pos >= WINDOW)
            return res;

        inserts_walked++;
        node = link_t'(pos);
        cur = link_t'(WINDOW + 1 + int'(text_at(node)));
        set_right(node, NIL);
        set_left(node, NIL);

        for (visits = 0; visits <= WINDOW; visits++)
        begin
            next = (diff >= 0) ? right_of(cur) : left_of(cur);
            if (next == NIL)
            begin
                if (diff >= 0)
                    set_right(cur, node);
                else
                    set_left(cur, node);
                set_parent(node, cur);
                break;
            end
            cur = next;
            diff = 0;
            for (n_cmp = 1; n_cmp < MATCH_MAX; n_cmp++)
            begin
                diff = int'(text_at(node + n_cmp)) - int'(text_at(cur + n_cmp));
                if (diff != 0)
                    break;
            end
            if (n_cmp > best_len)
            begin
                best_len = n_cmp;
                res.pos = cur[11:0];
                res.len = 5'(n_cmp);
                if (n_cmp >= MATCH_MAX)
                begin
                    full = 1'b1;
                    break;
                end
            end
        end

        if (!full && visits > WINDOW)
            runaway_walks++;

        // Full-length match: the new node takes the old node's place
        if (full)
        begin
            full_replacements++;
            up = parent_of(cur);
            lo = left_of(cur);
            hi = right_of(cur);
            set_parent(node, up);
            set_left(node, lo);
            set_right(node, hi);
            set_parent(lo, node);
            set_parent(hi, node);
            if (right_of(up) == cur)
                set_right(up, node);
            else
                set_left(up, node);
            set_parent(cur, NIL);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic send_request(input logic op, input logic [POS_W-1:0] pos,
                                input logic [7:0] val, input logic typed,
                                input match_t typed_want);
        match_t predicted;

        operation  <= op;
        position   <= pos;
        byte_value <= val;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_match(op, pos, val);
        pending_matches.push_back(typed ? typed_want : predicted);
        requests_sent++;
        if ((op == OP_WRITE && pos >= TEXT_DEPTH) || (op == OP_INSERT && pos >= WINDOW))
            far_requests++;
    endtask

    task automatic idle_for(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_results;
        start <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
    endtask

    // Every request gives one result, so compare each strobe with the oldest expectation
    always @(posedge clk)
    begin
        match_t want;

        if (rst_n && done)
        begin
            results_seen++;
            if (pending_matches.size() == 0)
            begin
                report_mismatch($sformatf("result with none expected: pos %0d len %0d",
                                          match_position, match_length));
            end
            else
            begin
                want = pending_matches.pop_front();
                if (match_position !== want.pos)
                    report_mismatch($sformatf("match_position %0d, expected %0d",
                                              match_position, want.pos));
                if (match_length !== want.len)
                    report_mismatch($sformatf("match_length %0d, expected %0d",
                                              match_length, want.len));
            end
        end
    end

    // Reset the count on every accepted request or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int unsigned r;
        int unsigned k;
        int unsigned counted;
        int unsigned wr_head;
        int unsigned ins_head;
        int unsigned lag;
        int unsigned pick;
        int unsigned gap_odds;
        int unsigned period;
        int unsigned mode_left;
        bit          drained;
        text_kind_t  text_kind;
        noise_kind_t noise_kind;
        logic [7:0]  pattern [4];
        logic [7:0]  rnd_val;

        rst_n      <= 1'b0;
        start      <= 1'b0;
        operation  <= OP_WRITE;
        position   <= '0;
        byte_value <= '0;
        mismatch_count = 0;
        requests_sent = 0;
        results_seen = 0;
        inserts_walked = 0;
        full_replacements = 0;
        runaway_walks = 0;
        far_requests = 0;
        for (k = 0; k < TEXT_DEPTH; k++)
            text_mem[k] = 8'h00;
        for (k = 0; k < LEFT_DEPTH; k++)
            left_link[k] = NIL;
        for (k = 0; k < RIGHT_DEPTH; k++)
            right_link[k] = NIL;
        for (k = 0; k < PARENT_DEPTH; k++)
            parent_link[k] = NIL;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows; a write row with a repeat count fills consecutive addresses
        for (r = 0; r < $size(directed_rows); r++)
        begin
            for (k = 0; k < directed_rows[r].reps; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    idle_for($urandom_range(1, 15));
                send_request(directed_rows[r].op, directed_rows[r].pos + POS_W'(k),
                             directed_rows[r].val, directed_rows[r].typed,
                             directed_rows[r].want);
            end
        end

        // Random part: text is written ahead of the insert point as a compressor
        // would, so every insert reads only bytes already written
        counted = 0;
        wr_head = 0;
        ins_head = 0;
        mode_left = 0;
        period = 1;
        text_kind = TEXT_NOISY;
        gap_odds = 0;
        drained = 1'b0;
        for (k = 0; k < 4; k++)
            pattern[k] = 8'h00;

        while (counted < RANDOM_REQUESTS)
        begin
            if (counted % 40 == 0)
                gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 5);
            if (counted >= RANDOM_REQUESTS - CALM_REQUESTS)
                gap_odds = 0;
            if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                idle_for($urandom_range(1, 15));
            if (!drained && counted >= RANDOM_REQUESTS / 2)
            begin
                wait_for_results();
                drained = 1'b1;
            end

            lag = wr_head - ins_head;
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                noise_kind = noise_kind_t'($urandom_range(0, 2));
                case (noise_kind)
                    NOISE_FAR_WRITE:
                    begin
                        send_request(OP_WRITE, POS_W'($urandom_range(TEXT_DEPTH, POS_MAX)),
                                     8'($urandom), 1'b0, '0);
                    end
                    NOISE_FAR_INSERT:
                    begin
                        send_request(OP_INSERT, POS_W'($urandom_range(WINDOW, POS_MAX)),
                                     8'($urandom), 1'b0, '0);
                    end
                    default:
                    begin
                        // Overwrite text already in the window, which skews the trees
                        if (wr_head != 0)
                        begin
                            send_request(OP_WRITE, POS_W'($urandom_range(0, wr_head - 1)),
                                         8'($urandom_range(0, TEXT_BYTE_MAX)), 1'b0, '0);
                            counted++;
                        end
                    end
                endcase
            end
            else if (lag < MATCH_MAX || (lag < 40 && pick < 55))
            begin
                if (mode_left == 0)
                begin
                    text_kind = text_kind_t'($urandom_range(0, 2));
                    period = $urandom_range(1, 4);
                    for (k = 0; k < 4; k++)
                        pattern[k] = 8'($urandom_range(0, TEXT_BYTE_MAX));
                    mode_left = $urandom_range(8, 48);
                end
                mode_left--;
                case (text_kind)
                    TEXT_NOISY:  rnd_val = 8'($urandom_range(0, TEXT_BYTE_MAX));
                    TEXT_SPARSE: rnd_val = pattern[$urandom_range(0, period - 1)];
                    default:     rnd_val = pattern[wr_head % period];
                endcase
                send_request(OP_WRITE, POS_W'(wr_head), rnd_val, 1'b0, '0);
                wr_head++;
                counted++;
            end
            else
            begin
                send_request(OP_INSERT, POS_W'(ins_head), 8'($urandom), 1'b0, '0);
                ins_head++;
                counted++;
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d requests, %0d of them out of range; %0d tree walks,",
                 requests_sent, far_requests, inserts_walked);
        $display("%0d full-length replacements, %0d runaway walks; %0d results checked",
                 full_replacements, runaway_walks, results_seen);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- lzss_tree_insert_match_unit.f -----
design/lzti_pkg.sv
design/lzti_ram.sv
design/lzss_tree_insert_match_unit.sv
tb/sv/tb_top.sv
